### sv/transport_packet_framer_defines.svh
// assertion helpers shared by the framer modules
// they expect clk and arst_n in the enclosing scope
`ifndef TRANSPORT_PACKET_FRAMER_DEFINES_SVH
`define TRANSPORT_PACKET_FRAMER_DEFINES_SVH

// same-cycle implication
`define TPF_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TPF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tpf_pkg.sv
`timescale 1ns / 1ps

package tpf_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] MAX_LEN   = 8'd248;
	localparam logic [7:0] FRAG_FLAG = 8'h08;
	localparam logic [7:0] PORT_RESET = 8'd21;

	// register indexes on the configuration port
	localparam logic REG_SRC_PORT = 1'b0;
	localparam logic REG_DST_PORT = 1'b1;

	// one classified input item
	typedef struct packed {
		logic       has_header;
		logic       has_data;
		logic       is_end;
		logic [7:0] data;
		logic [7:0] len;
		logic [3:0] frag;
	} cmd_t;

	typedef enum logic [3:0] {
		PH_START,
		PH_HDR0,
		PH_HDR1,
		PH_HDR2,
		PH_HDR3,
		PH_HDR4,
		PH_DATA,
		PH_CKH,
		PH_CKL
	} phase_t;

endpackage

### sv/tpf_front.sv
`timescale 1ns / 1ps
`include "transport_packet_framer_defines.svh"

module tpf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    data_byte,
	input  logic [7:0]    payload_length,
	input  logic [3:0]    fragment,
	output logic          cmd_valid,
	output tpf_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import tpf_pkg::*;

	logic              in_packet_q;
	logic [7:0]        remaining_q;
	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              wr_en;
	logic              rd_en;
	logic [7:0]        len_sat;
	cmd_t              new_cmd;

	assign full      = (count_q == QCNT_W'(QDEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = mem_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_pop && cmd_valid;

	assign len_sat = (payload_length > MAX_LEN) ? MAX_LEN : payload_length;

	always_comb begin
		new_cmd.data = data_byte;
		new_cmd.len  = len_sat;
		new_cmd.frag = fragment;
		if (!in_packet_q) begin
			new_cmd.has_header = 1'b1;
			new_cmd.has_data   = (len_sat != 8'd0);
			new_cmd.is_end     = (len_sat <= 8'd1);
		end else begin
			new_cmd.has_header = 1'b0;
			new_cmd.has_data   = 1'b1;
			new_cmd.is_end     = (remaining_q == 8'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_packet_q <= 1'b0;
			remaining_q <= 8'd0;
		end else if (wr_en) begin
			if (!in_packet_q) begin
				in_packet_q <= (len_sat > 8'd1);
				remaining_q <= (len_sat == 8'd0) ? 8'd0 : len_sat - 8'd1;
			end else begin
				in_packet_q <= (remaining_q != 8'd1);
				remaining_q <= remaining_q - 8'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`TPF_ASSERT(a_count_bound, 1'b1, count_q <= QCNT_W'(QDEPTH), "command queue overfilled")
	`TPF_ASSERT(a_in_packet_left, in_packet_q, remaining_q != 8'd0,
		"inside a packet with no bytes left")
	`TPF_ASSERT_NEXT(a_end_closes, wr_en && new_cmd.is_end, !in_packet_q,
		"packet end did not return to idle")

endmodule

### sv/tpf_back.sv
`timescale 1ns / 1ps
`include "transport_packet_framer_defines.svh"

module tpf_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  tpf_pkg::cmd_t cmd,
	output logic          cmd_pop,
	input  logic [7:0]    sport,
	input  logic [7:0]    dst_port,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic          is_last
);
	import tpf_pkg::*;

	phase_t      phase_q;
	phase_t      phase_eff;
	phase_t      phase_nxt;
	logic [15:0] parity_q;
	logic        odd_q;
	logic [3:0]  seq_q;
	logic [3:0]  frag_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        is_last_q;
	logic        advance;
	logic        emit;
	logic [7:0]  byte_nxt;
	logic        absorb;
	logic        last_nxt;
	logic        done;

	assign advance  = !out_valid_q || pop;
	assign emit     = cmd_valid && advance;
	assign cmd_pop  = emit && done;
	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign is_last  = is_last_q;

	always_comb begin
		phase_eff = phase_q;
		if (phase_q == PH_START) begin
			phase_eff = cmd.has_header ? PH_HDR0 : PH_DATA;
		end
		byte_nxt  = 8'd0;
		absorb    = 1'b1;
		last_nxt  = 1'b0;
		done      = 1'b0;
		phase_nxt = PH_START;
		case (phase_eff)
			PH_HDR0: begin
				byte_nxt  = (cmd.frag != 4'd0) ? FRAG_FLAG : 8'd0;
				phase_nxt = PH_HDR1;
			end
			PH_HDR1: begin
				byte_nxt  = {seq_q, cmd.frag};
				phase_nxt = PH_HDR2;
			end
			PH_HDR2: begin
				byte_nxt  = sport;
				phase_nxt = PH_HDR3;
			end
			PH_HDR3: begin
				byte_nxt  = dst_port;
				phase_nxt = PH_HDR4;
			end
			PH_HDR4: begin
				byte_nxt  = cmd.len;
				phase_nxt = cmd.has_data ? PH_DATA : PH_CKH;
			end
			PH_DATA: begin
				byte_nxt = cmd.data;
				if (cmd.is_end) begin
					phase_nxt = PH_CKH;
				end else begin
					done = 1'b1;
				end
			end
			PH_CKH: begin
				byte_nxt  = parity_q[15:8];
				absorb    = 1'b0;
				phase_nxt = PH_CKL;
			end
			PH_CKL: begin
				byte_nxt = parity_q[7:0];
				absorb   = 1'b0;
				last_nxt = 1'b1;
				done     = 1'b1;
			end
			default: begin
				absorb = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_START;
			parity_q <= 16'd0;
			odd_q    <= 1'b0;
			seq_q    <= 4'd0;
			frag_q   <= 4'd0;
		end else if (emit) begin
			phase_q <= phase_nxt;
			if (phase_eff == PH_HDR0) begin
				frag_q <= cmd.frag;
			end
			if (phase_eff == PH_CKL) begin
				parity_q <= 16'd0;
				odd_q    <= 1'b0;
				if (frag_q == 4'd0) begin
					seq_q <= seq_q + 4'd1;
				end
			end else if (absorb) begin
				parity_q <= parity_q ^ (odd_q ? {8'd0, byte_nxt} : {byte_nxt, 8'd0});
				odd_q    <= !odd_q;
			end
		end
	end

	// output register parts the sequencer from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_nxt;
			is_last_q  <= last_nxt;
		end
	end

	`TPF_ASSERT_NEXT(a_ckl_clears, emit && phase_eff == PH_CKL,
		parity_q == 16'd0 && !odd_q, "checksum state not cleared after packet")
	`TPF_ASSERT(a_hdr_even, emit && phase_eff == PH_HDR0, parity_q == 16'd0 && !odd_q,
		"header started with stale checksum state")
	`TPF_ASSERT_NEXT(a_seq_hold, !(emit && phase_eff == PH_CKL), $stable(seq_q),
		"sequence number moved outside a packet end")
	`TPF_ASSERT_NEXT(a_last_from_ckl, emit && phase_eff == PH_CKL, out_valid_q && is_last_q,
		"final checksum byte not flagged")

endmodule

### sv/transport_packet_framer.sv
`timescale 1ns / 1ps

// Transport packet framer: takes payload bytes one per transfer and emits a framed
// packet one byte per transfer: five header bytes (fragment flag, sequence/fragment,
// source port, destination port, length), the payload, then a 16-bit XOR checksum high
// byte first, with is_last on the final byte. The first item of a packet carries the
// length (saturated at 248) and fragment; a zero-length packet takes one item whose
// byte is dropped. The input side classifies items into a four-entry command queue and
// takes one item per cycle while that queue has room; the output sequencer emits one
// byte per cycle unless out_byte waits unpopped, and that sequencer sets the sustained
// rate. Results sit in an output register, so the input keeps accepting while a byte
// waits to be popped. Source and destination ports reset to 21; the user writes them at
// APB byte addresses 0 and 4 only while idle, which the block does not enforce.

module transport_packet_framer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic [7:0]  payload_length,
	input  logic [3:0]  fragment,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        is_last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tpf_pkg::*;

	logic [7:0] sport_q;
	logic [7:0] dst_port_q;
	logic       cmd_valid;
	cmd_t       cmd;
	logic       cmd_pop;
	logic       reg_sel;
	logic       wr_xfer;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_xfer = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sport_q    <= PORT_RESET;
			dst_port_q <= PORT_RESET;
		end else if (wr_xfer) begin
			case (reg_sel)
				REG_SRC_PORT: sport_q <= pwdata[7:0];
				REG_DST_PORT: dst_port_q <= pwdata[7:0];
				default:      sport_q <= sport_q;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_SRC_PORT: prdata = {24'd0, sport_q};
			REG_DST_PORT: prdata = {24'd0, dst_port_q};
			default:      prdata = 32'd0;
		endcase
	end

	tpf_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.payload_length (payload_length),
		.fragment       (fragment),
		.cmd_valid      (cmd_valid),
		.cmd            (cmd),
		.cmd_pop        (cmd_pop)
	);

	tpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.sport     (sport_q),
		.dst_port  (dst_port_q),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.is_last   (is_last)
	);

endmodule
